@@ design/nfida_pkg.sv @@
// Shared constants and types for the next-fit ID bitmap allocator.
`default_nettype none
package nfida_pkg;

  localparam int NUM_IDS   = 64;
  localparam int ID_W      = 6;
  localparam int CELL_BITS = 8;
  localparam int NUM_CELLS = NUM_IDS / CELL_BITS;
  localparam int BIT_W     = 3;
  localparam int CELL_W    = ID_W - BIT_W;
  localparam int STEP_W    = 4;
  localparam int MODE_W    = 2;

  // the token visits the start cell twice: at step zero and at this step
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_CELLS);

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic              want_used;
    logic [STEP_W-1:0] step;
    logic [BIT_W-1:0]  off;
  } tok_t;

  typedef struct packed {
    logic              valid;
    logic [CELL_W-1:0] cell_sel;
    logic              want_used;
    logic [BIT_W-1:0]  off;
  } inj_t;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] id;
    logic            value;
  } wr_t;

  typedef struct packed {
    logic            hit;
    logic            miss;
    logic [ID_W-1:0] id;
  } res_t;

endpackage
`default_nettype wire

@@ design/nfida_cell.sv @@
// One cell of the search ring: eight usage bits and a circulating search token.
`default_nettype none
module nfida_cell (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  [nfida_pkg::CELL_W-1:0]        cell_idx,
  input  wire  nfida_pkg::inj_t               inj,
  input  wire  nfida_pkg::wr_t                wr,
  input  wire  nfida_pkg::tok_t               tok_in,
  output nfida_pkg::tok_t                     tok_out,
  output nfida_pkg::res_t                     res,
  output logic [nfida_pkg::CELL_BITS-1:0]     bits
);
  import nfida_pkg::*;

  tok_t                 tok;
  logic [CELL_BITS-1:0] cand;
  logic [CELL_BITS-1:0] mask;
  logic [CELL_BITS-1:0] match;
  logic [BIT_W-1:0]     pos;
  logic                 found;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
      tok  <= '0;
    end else begin
      if (wr.en && wr.id[ID_W-1:BIT_W] == cell_idx) begin
        bits[wr.id[BIT_W-1:0]] <= wr.value;
      end
      if (inj.valid && inj.cell_sel == cell_idx) begin
        tok.valid     <= 1'b1;
        tok.want_used <= inj.want_used;
        tok.step      <= '0;
        tok.off       <= inj.off;
      end else begin
        tok <= tok_in;
      end
    end
  end

  always_comb begin
    cand = tok.want_used ? bits : ~bits;
    // first visit looks above the start, the return visit at and below it
    for (int j = 0; j < CELL_BITS; j++) begin
      if (tok.step == '0) begin
        mask[j] = BIT_W'(j) > tok.off;
      end else if (tok.step == LAST_STEP) begin
        mask[j] = BIT_W'(j) <= tok.off;
      end else begin
        mask[j] = 1'b1;
      end
    end
    match = cand & mask;
    found = |match;
    pos   = '0;
    for (int j = CELL_BITS - 1; j >= 0; j--) begin
      if (match[j]) begin
        pos = BIT_W'(j);
      end
    end
  end

  always_comb begin
    res.hit  = tok.valid && found;
    res.miss = tok.valid && !found && tok.step == LAST_STEP;
    res.id   = {cell_idx, pos};
    tok_out       = tok;
    tok_out.valid = tok.valid && !found && tok.step != LAST_STEP;
    tok_out.step  = tok.step + 1'b1;
  end

endmodule
`default_nettype wire

@@ design/next_fit_id_bitmap_allocator.sv @@
// Next-fit ID allocator: request sequencer over a ring of bitmap cells.
// A request goes from IDLE to START; free and test then go to FINISH, while allocate
// and next-used go to SEARCH, where the search token steps one cell per cycle around
// the ring of 8 cells (start cell visited twice) until it hits or misses, then FINISH.
// FINISH raises m_tvalid once the output is free; a new request is taken only in IDLE.
// Reset: synchronous; all IDs free, last allocated ID set to the highest ID.
`default_nettype none
module next_fit_id_bitmap_allocator (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [1:0] mode, [7:2] id_in
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata    // [5:0] id_out, [6] was_used, [7] failed
);
  import nfida_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_START  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state;
  logic [MODE_W-1:0] req_mode;
  logic [ID_W-1:0]   req_id;
  logic [ID_W-1:0]   last_alloc;
  logic [ID_W-1:0]   res_id;
  logic              res_was;
  logic              res_fail;

  logic [NUM_IDS-1:0] all_bits;
  tok_t               tok_o [NUM_CELLS];
  res_t               cres  [NUM_CELLS];
  inj_t               inj;
  wr_t                wr;
  logic               any_hit;
  logic               any_miss;
  logic [ID_W-1:0]    found_id;
  logic [ID_W-1:0]    start_id;
  logic               is_search;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    nfida_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (CELL_W'(g)),
      .inj      (inj),
      .wr       (wr),
      .tok_in   (tok_o[(g + NUM_CELLS - 1) % NUM_CELLS]),
      .tok_out  (tok_o[g]),
      .res      (cres[g]),
      .bits     (all_bits[g*CELL_BITS +: CELL_BITS])
    );
  end

  always_comb begin
    any_hit  = 1'b0;
    any_miss = 1'b0;
    found_id = '0;
    for (int g = 0; g < NUM_CELLS; g++) begin
      any_hit  = any_hit | cres[g].hit;
      any_miss = any_miss | cres[g].miss;
      if (cres[g].hit) begin
        found_id = found_id | cres[g].id;
      end
    end
  end

  always_comb begin
    is_search     = req_mode == MODE_ALLOC || req_mode == MODE_NEXT;
    start_id      = (req_mode == MODE_ALLOC) ? last_alloc : req_id;
    inj.valid     = state == ST_START && is_search;
    inj.cell_sel  = start_id[ID_W-1:BIT_W];
    inj.off       = start_id[BIT_W-1:0];
    inj.want_used = req_mode == MODE_NEXT;

    wr = '0;
    if (state == ST_START && req_mode == MODE_FREE) begin
      wr.en    = 1'b1;
      wr.id    = req_id;
      wr.value = 1'b0;
    end else if (state == ST_SEARCH && any_hit && req_mode == MODE_ALLOC) begin
      wr.en    = 1'b1;
      wr.id    = found_id;
      wr.value = 1'b1;
    end
  end

  assign s_tready = state == ST_IDLE && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      last_alloc <= ID_W'(NUM_IDS - 1);
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req_mode <= s_tdata[MODE_W-1:0];
            req_id   <= s_tdata[MODE_W +: ID_W];
            state    <= ST_START;
          end
        end
        ST_START: begin
          res_was  <= (req_mode == MODE_ALLOC) ? 1'b0 : all_bits[req_id];
          res_id   <= req_id;
          res_fail <= 1'b0;
          state    <= is_search ? ST_SEARCH : ST_FINISH;
        end
        ST_SEARCH: begin
          if (any_hit) begin
            res_id <= found_id;
            if (req_mode == MODE_ALLOC) begin
              last_alloc <= found_id;
            end
            state <= ST_FINISH;
          end else if (any_miss) begin
            res_id   <= '0;
            res_fail <= 1'b1;
            state    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_fail, res_was, res_id};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the next-fit ID bitmap allocator: bitmap scoreboard and stream drivers.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfida_pkg::*;

  // m_tdata layout, MSB first: failed, was_used, id_out
  typedef struct packed {
    logic            failed;
    logic            was_used;
    logic [ID_W-1:0] id_out;
  } lookup_result_t;

  class id_bitmap_scoreboard;
    logic [NUM_IDS-1:0] in_use;
    logic [ID_W-1:0]    last_alloc;
    lookup_result_t     expected_q[$];
    int                 errors;

    function new();
      in_use     = '0;
      last_alloc = ID_W'(NUM_IDS - 1);
      errors     = 0;
    endfunction

    function logic [ID_W-1:0] next_id(input logic [ID_W-1:0] id);
      return (id == ID_W'(NUM_IDS - 1)) ? '0 : id + 1'b1;
    endfunction

    function void note_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
      lookup_result_t r;
      logic [ID_W-1:0] cur;
      bit              found;
      int              k;
      r.id_out   = id;
      r.was_used = 1'b0;
      r.failed   = 1'b0;
      found      = 1'b0;
      case (mode)
        MODE_ALLOC: begin
          cur = last_alloc;
          for (k = 0; k < NUM_IDS && !found; k++) begin
            cur   = next_id(cur);
            found = !in_use[cur];
          end
          if (found) begin
            in_use[cur] = 1'b1;
            last_alloc  = cur;
            r.id_out    = cur;
          end else begin
            r.failed = 1'b1;
            r.id_out = '0;
          end
        end
        MODE_FREE: begin
          r.was_used = in_use[id];
          in_use[id] = 1'b0;
        end
        MODE_TEST: begin
          r.was_used = in_use[id];
        end
        default: begin
          r.was_used = in_use[id];
          // the given ID itself comes up last in the scan
          cur = id;
          for (k = 0; k < NUM_IDS && !found; k++) begin
            cur   = next_id(cur);
            found = in_use[cur];
          end
          if (found) begin
            r.id_out = cur;
          end else begin
            r.failed = 1'b1;
            r.id_out = '0;
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    task report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(input logic [7:0] data);
      lookup_result_t got;
      lookup_result_t want;
      got = data;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", data));
      end else begin
        want = expected_q.pop_front();
        if (got.id_out !== want.id_out)
          report_mismatch($sformatf("id_out %0d, expected %0d", got.id_out, want.id_out));
        if (got.was_used !== want.was_used)
          report_mismatch($sformatf("was_used %b, expected %b", got.was_used, want.was_used));
        if (got.failed !== want.failed)
          report_mismatch($sformatf("failed %b, expected %b", got.failed, want.failed));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;   // [1:0] mode, [7:2] id_in
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;        // [5:0] id_out, [6] was_used, [7] failed

  id_bitmap_scoreboard board = new();
  bit idle_on = 1'b1;
  int results_seen = 0;

  next_fit_id_bitmap_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // valid is only dropped when a gap follows, so it never toggles within one step
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {id, mode};
    do @(posedge clk); while (!s_tready);
    board.note_request(mode, id);
  endtask

  task automatic run_phase(input int count, input int alloc_pct, input int free_pct,
                           input int test_pct, input bit idle);
    int               n;
    int               r;
    int               k;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    idle_on = idle;
    for (n = 0; n < count; n++) begin
      r  = $urandom_range(0, 99);
      id = ID_W'($urandom_range(0, NUM_IDS - 1));
      if (r < alloc_pct) begin
        mode = MODE_ALLOC;
      end else if (r < alloc_pct + free_pct) begin
        mode = MODE_FREE;
        // mostly free an ID that is actually held
        if ($urandom_range(0, 3) != 0) begin
          for (k = 0; k < NUM_IDS && !board.in_use[id]; k++) id = board.next_id(id);
        end
      end else if (r < alloc_pct + free_pct + test_pct) begin
        mode = MODE_TEST;
      end else begin
        mode = MODE_NEXT;
      end
      send_request(mode, id);
    end
  endtask

  // receiver: random stall per result, one long hold-off to back the block up
  initial begin
    int  hold;
    bit  pressure_done;
    hold = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else begin
        if (m_tvalid && m_tready) begin
          board.check_result(m_tdata);
          results_seen++;
          hold = idle_on ? $urandom_range(0, 4) : 0;
        end
        if (!pressure_done && results_seen == 600) begin
          pressure_done = 1'b1;
          hold = 400;
        end
        if (hold > 0) begin
          m_tready <= 1'b0;
          hold--;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty map, first allocations, wrap of the next-used scan
    send_request(MODE_NEXT, 6'd0);     // nothing used: fails
    send_request(MODE_TEST, 6'd0);
    send_request(MODE_FREE, 6'd63);    // free of an unused ID
    send_request(MODE_ALLOC, 6'd63);   // pointer wraps from the top to 0
    send_request(MODE_ALLOC, 6'd0);
    send_request(MODE_TEST, 6'd1);
    send_request(MODE_NEXT, 6'd63);
    send_request(MODE_NEXT, 6'd1);     // wraps to 0
    send_request(MODE_NEXT, 6'd0);
    send_request(MODE_FREE, 6'd0);
    send_request(MODE_NEXT, 6'd1);     // only itself is used
    send_request(MODE_ALLOC, 6'd42);
    send_request(MODE_TEST, 6'd63);
    send_request(MODE_FREE, 6'd1);
    send_request(MODE_FREE, 6'd2);
    send_request(MODE_NEXT, 6'd42);    // empty again
    send_request(MODE_ALLOC, 6'd21);
    send_request(MODE_TEST, 6'd3);
    send_request(MODE_FREE, 6'd3);

    // random: fill to full, churn, drain to empty, repeat
    run_phase(150, 80, 5, 10, 1'b1);
    run_phase(400, 40, 35, 10, 1'b1);
    run_phase(200, 5, 75, 10, 1'b1);
    run_phase(300, 30, 30, 20, 1'b0);
    run_phase(200, 70, 10, 10, 1'b1);
    run_phase(350, 35, 35, 15, 1'b1);
    run_phase(300, 10, 60, 15, 1'b1);
    s_tvalid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS next_fit_id_bitmap_allocator");
    end else begin
      $display("FAIL next_fit_id_bitmap_allocator");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL next_fit_id_bitmap_allocator");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
design/nfida_pkg.sv
design/nfida_cell.sv
design/next_fit_id_bitmap_allocator.sv
verif/tb.sv
